### sv/windowed_period_statistics_macros.svh
// Assertion macros shared by the statistics block
`ifndef WINDOWED_PERIOD_STATISTICS_MACROS_SVH
`define WINDOWED_PERIOD_STATISTICS_MACROS_SVH
`ifndef ASSERT_OFF
`define WPS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define WPS_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define WPS_ASSERT(lbl, clk, rstn, prop)
`define WPS_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### sv/wps_pkg.sv
package wps_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int DATA_W       = 32;
    localparam int WIN_W        = 16;
    localparam int FQ_DEPTH     = 2;
    localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

    localparam logic [1:0] MODE_IN  = 2'd0;
    localparam logic [1:0] MODE_OUT = 2'd1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  channel;
        logic [31:0] timestamp;
    } t_in;

    typedef struct packed {
        logic [31:0] avg_period;
        logic [31:0] min_period;
        logic [31:0] max_period;
        logic [31:0] run_time;
        logic        window_done;
    } t_out;

    typedef enum logic [1:0] {
        OP_CHECK_IN,
        OP_CHECK_OUT,
        OP_READ
    } t_op;

    // classified command passed from front to back
    typedef struct packed {
        t_op         op;
        logic        bad_ch;
        logic [2:0]  chan;
        logic [31:0] stamp;
    } t_cmd;

    typedef enum logic {
        S_IDLE,
        S_DIV
    } t_state;

    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;

endpackage

### sv/wps_front.sv
module wps_front
    import wps_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    input  t_in  i_item,
    output logic full,
    output logic o_cmd_valid,
    output t_cmd o_cmd,
    input  logic i_cmd_take
);

    localparam int PTR_W = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(FQ_DEPTH + 1);

    t_cmd              r_q [FQ_DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_cnt;
    t_cmd              cls;
    logic              wr_en;
    logic              rd_en;

    // classify the incoming item
    always_comb begin
        cls.stamp  = i_item.timestamp;
        cls.chan   = i_item.channel;
        cls.bad_ch = ({29'd0, i_item.channel} >= NUM_CHANNELS);
        case (i_item.mode)
            MODE_IN:  cls.op = OP_CHECK_IN;
            MODE_OUT: cls.op = OP_CHECK_OUT;
            default:  cls.op = OP_READ;
        endcase
    end

    assign full        = (r_cnt == CNT_W'(FQ_DEPTH));
    assign wr_en       = push && !full;
    assign o_cmd_valid = (r_cnt != '0);
    assign rd_en       = i_cmd_take && o_cmd_valid;
    assign o_cmd       = r_q[r_rd];

    // command queue storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr] <= cls;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == PTR_W'(FQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == PTR_W'(FQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### sv/wps_div.sv
module wps_div
    import wps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(DATA_W);

    logic [DATA_W:0]   r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_dvs;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   rem_sub;
    logic              fits;

    // one quotient bit per cycle, restoring
    assign rem_sh  = {r_rem[DATA_W-1:0], r_quo[DATA_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign fits    = (rem_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? rem_sub : rem_sh;
            r_quo <= {r_quo[DATA_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    // a zero divisor yields zero
    assign o_quot = (r_dvs == '0) ? '0 : r_quo;

endmodule

### sv/wps_back.sv
`include "windowed_period_statistics_macros.svh"
module wps_back
    import wps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [WIN_W-1:0] i_window,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_cmd_take,
    output logic             empty,
    output t_out             o_result,
    input  logic             pop
);

    logic [DATA_W-1:0] r_entry [NUM_CHANNELS];
    logic [DATA_W-1:0] r_min   [NUM_CHANNELS];
    logic [DATA_W-1:0] r_max   [NUM_CHANNELS];
    logic [DATA_W-1:0] r_sum   [NUM_CHANNELS];
    logic [DATA_W-1:0] r_count [NUM_CHANNELS];
    logic [DATA_W-1:0] r_total [NUM_CHANNELS];
    logic [DATA_W-1:0] r_havg  [NUM_CHANNELS];
    logic [DATA_W-1:0] r_hmin  [NUM_CHANNELS];
    logic [DATA_W-1:0] r_hmax  [NUM_CHANNELS];

    t_state            r_state;
    t_state            n_state;
    logic [CH_W-1:0]   r_ch;
    logic              r_out_valid;
    t_out              r_out;
    t_div_ctl          div_ctl;
    logic              div_done;
    logic [DATA_W-1:0] quot;

    logic [CH_W-1:0]   ch;
    logic              slot_free;
    logic              go;
    logic              is_out;
    logic [DATA_W-1:0] period;
    logic [DATA_W-1:0] min_new;
    logic [DATA_W-1:0] max_new;
    logic [DATA_W-1:0] sum_new;
    logic [DATA_W-1:0] cnt_new;
    logic [DATA_W-1:0] total_new;
    logic              latch;

    // per-event arithmetic on the addressed channel
    assign ch        = i_cmd.chan[CH_W-1:0];
    assign is_out    = (i_cmd.op == OP_CHECK_OUT) && !i_cmd.bad_ch;
    assign period    = i_cmd.stamp - r_entry[ch];
    assign min_new   = (period < r_min[ch]) ? period : r_min[ch];
    assign max_new   = (period > r_max[ch]) ? period : r_max[ch];
    assign sum_new   = r_sum[ch] + period;
    assign cnt_new   = r_count[ch] + 1'b1;
    assign total_new = r_total[ch] + period;
    assign latch     = is_out && (i_window != '0)
                       && (cnt_new >= {{(DATA_W-WIN_W){1'b0}}, i_window});
    assign slot_free = !r_out_valid || pop;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_cmd_valid && slot_free && latch) n_state = S_DIV;
            S_DIV:   if (div_ctl.done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        go            = 1'b0;
        div_ctl.start = 1'b0;
        div_ctl.done  = div_done;
        case (r_state)
            S_IDLE: begin
                go            = i_cmd_valid && slot_free;
                div_ctl.start = i_cmd_valid && slot_free && latch;
            end
            default: begin
                go            = 1'b0;
                div_ctl.start = 1'b0;
            end
        endcase
    end

    assign o_cmd_take = go;

    wps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_ctl.start),
        .i_dividend (sum_new),
        .i_divisor  (cnt_new),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // channel statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_entry[i] <= '0;
                r_min[i]   <= ALL_ONES;
                r_max[i]   <= '0;
                r_sum[i]   <= '0;
                r_count[i] <= '0;
                r_total[i] <= '0;
                r_havg[i]  <= '0;
                r_hmin[i]  <= '0;
                r_hmax[i]  <= '0;
            end
        end else begin
            if (go && !i_cmd.bad_ch && i_cmd.op == OP_CHECK_IN) begin
                r_entry[ch] <= i_cmd.stamp;
            end
            if (go && is_out) begin
                r_total[ch] <= total_new;
                if (latch) begin
                    r_hmin[ch]  <= min_new;
                    r_hmax[ch]  <= max_new;
                    r_min[ch]   <= ALL_ONES;
                    r_max[ch]   <= '0;
                    r_sum[ch]   <= '0;
                    r_count[ch] <= '0;
                end else begin
                    r_min[ch]   <= min_new;
                    r_max[ch]   <= max_new;
                    r_sum[ch]   <= sum_new;
                    r_count[ch] <= cnt_new;
                end
            end
            if (r_state == S_DIV && div_ctl.done) begin
                r_havg[r_ch] <= quot;
            end
        end
    end

    // channel under division
    always_ff @(posedge i_clk) begin
        if (div_ctl.start) begin
            r_ch <= ch;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (go && !latch) begin
            if (i_cmd.bad_ch) begin
                r_out <= '0;
            end else begin
                r_out.avg_period  <= r_havg[ch];
                r_out.min_period  <= r_hmin[ch];
                r_out.max_period  <= r_hmax[ch];
                r_out.run_time    <= is_out ? total_new : r_total[ch];
                r_out.window_done <= 1'b0;
            end
        end else if (r_state == S_DIV && div_ctl.done) begin
            r_out.avg_period  <= quot;
            r_out.min_period  <= r_hmin[r_ch];
            r_out.max_period  <= r_hmax[r_ch];
            r_out.run_time    <= r_total[r_ch];
            r_out.window_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((go && !latch) || (r_state == S_DIV && div_ctl.done)) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign empty    = !r_out_valid;
    assign o_result = r_out;

    // no result is waiting while a window average is being divided
    `WPS_NEVER(a_no_out_in_div, i_clk, i_rst_n, r_state == S_DIV && r_out_valid)
    // a closed window is only reported right after the divider finishes
    `WPS_ASSERT(a_done_after_div, i_clk, i_rst_n, $rose(r_out_valid) && r_out.window_done |-> $past(r_state) == S_DIV)
    // no command is taken while dividing
    `WPS_NEVER(a_no_take_in_div, i_clk, i_rst_n, r_state == S_DIV && o_cmd_take)

endmodule

### sv/windowed_period_statistics.sv
// Path: an item is registered in the command queue, then in the result register
// for check-in, read and non-closing check-outs, else after the divider.
// Throughput: one item per cycle while no window closes and results are popped;
// closing check-outs hold the back end (start, 32-step bit-serial divide, write-back).
// Reset: synchronous active-low; clears queues, window register (0) and all
// per-channel statistics (running minimum to all ones, the rest to zero).
module windowed_period_statistics
    import wps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    input  t_in               i_item,
    output logic              full,
    output logic              empty,
    input  logic              pop,
    output t_out              o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [WIN_W-1:0]  i_cfg_data
);

    logic [WIN_W-1:0] r_window;
    logic             cmd_valid;
    t_cmd             cmd;
    logic             cmd_take;

    assign o_cfg_ready = 1'b1;

    // window size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
        end else if (i_cfg_valid) begin
            r_window <= i_cfg_data;
        end
    end

    wps_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_item      (i_item),
        .full        (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    wps_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_window    (r_window),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .empty       (empty),
        .o_result    (o_result),
        .pop         (pop)
    );

endmodule
